/* sv/rlbd_pkg.sv */
`default_nettype none
package rlbd_pkg;

    localparam int WINDOW      = 1024;
    localparam int TOP_COUNT   = 5;
    localparam int SAMPLE_BITS = 12;

    // window length is a power of two, the mean square is a shift
    localparam int WIN_LOG = $clog2(WINDOW);
    localparam int CNT_W   = WIN_LOG;
    localparam int SUM_W   = 2 * SAMPLE_BITS - 1 + WIN_LOG;
    localparam int MS_W    = SUM_W + 8 - WIN_LOG;
    localparam int RT_W    = (MS_W + 1) / 2;
    localparam int LVL_W   = 16;
    localparam int TCNT_W  = $clog2(TOP_COUNT + 1);
    localparam int DN_W    = LVL_W + TCNT_W;
    localparam int DET_W   = LVL_W + 4;
    localparam int STEP_N  = (RT_W > DN_W) ? RT_W : DN_W;
    localparam int STEP_W  = $clog2(STEP_N);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    localparam int BAND_LO    = 9;
    localparam int BAND_SCALE = 10;
    localparam int BAND_HI    = 11;

    localparam logic [1:0] MODE_DETECT = 2'd0;
    localparam logic [1:0] MODE_CAL    = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [1:0] KIND_DETECT = 2'd0;
    localparam logic [1:0] KIND_CAL    = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic CFG_STORED_LEVEL = 1'b0;
    localparam logic CFG_STORED_VALID = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SUM_W-1:0] sum;
    } t_job;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LVL_W-1:0] rms;
        logic             detected;
        logic [LVL_W-1:0] new_level;
        logic             no_windows;
    } t_result;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             valid;
    } t_cfg;

endpackage
`default_nettype wire

/* sv/rlbd_front.sv */
`default_nettype none
module rlbd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [rlbd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output rlbd_pkg::t_job                     o_job
);

    localparam int SB = rlbd_pkg::SAMPLE_BITS;
    localparam logic [SB-1:0] CENTRE = {1'b1, {(SB-1){1'b0}}};

    logic [rlbd_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [rlbd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_wmode, n_wmode;

    logic                       accept;
    logic                       is_sample;
    logic                       is_finish;
    logic [SB-1:0]              dev;
    logic [2*SB-1:0]            sq;
    logic [rlbd_pkg::SUM_W-1:0] base_sum;
    logic [rlbd_pkg::SUM_W-1:0] add_sum;
    logic [rlbd_pkg::CNT_W-1:0] base_cnt;
    logic                       last;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid & ~i_q_full;
    assign is_sample  = (i_mode == rlbd_pkg::MODE_DETECT) || (i_mode == rlbd_pkg::MODE_CAL);
    assign is_finish  = (i_mode == rlbd_pkg::MODE_FINISH);

    assign dev      = (i_sample >= CENTRE) ? (i_sample - CENTRE) : (CENTRE - i_sample);
    assign sq       = {{SB{1'b0}}, dev} * {{SB{1'b0}}, dev};
    assign base_sum = (i_mode[0] == r_wmode) ? r_sum : '0;
    assign base_cnt = (i_mode[0] == r_wmode) ? r_cnt : '0;
    assign add_sum  = base_sum + rlbd_pkg::SUM_W'(sq);
    assign last     = (base_cnt == rlbd_pkg::CNT_W'(rlbd_pkg::WINDOW - 1));

    assign o_push   = accept & (is_finish | (is_sample & last));
    assign o_job.kind = i_mode;
    assign o_job.sum  = add_sum;

    always_comb begin
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_wmode = r_wmode;
        if (accept && is_finish) begin
            n_sum = '0;
            n_cnt = '0;
        end else if (accept && is_sample) begin
            n_wmode = i_mode[0];
            if (last) begin
                n_sum = '0;
                n_cnt = '0;
            end else begin
                n_sum = add_sum;
                n_cnt = base_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_wmode <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_wmode <= n_wmode;
        end
    end

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("job pushed into a full queue");

endmodule
`default_nettype wire

/* sv/rlbd_queue.sv */
`default_nettype none
module rlbd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rlbd_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output rlbd_pkg::t_job      o_job
);

    rlbd_pkg::t_job                r_mem [rlbd_pkg::QDEPTH];
    logic [rlbd_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [rlbd_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (rlbd_pkg::QPTR_W+1)'(rlbd_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (rlbd_pkg::QPTR_W+1)'(rlbd_pkg::QDEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

/* sv/rlbd_back.sv */
`default_nettype none
module rlbd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rlbd_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    input  wire rlbd_pkg::t_job i_q_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output rlbd_pkg::t_result   o_res
);

    localparam int RT_W   = rlbd_pkg::RT_W;
    localparam int LVL_W  = rlbd_pkg::LVL_W;
    localparam int TOP    = rlbd_pkg::TOP_COUNT;
    localparam int TCNT_W = rlbd_pkg::TCNT_W;
    localparam int DN_W   = rlbd_pkg::DN_W;
    localparam int DET_W  = rlbd_pkg::DET_W;
    localparam int SUM_W  = rlbd_pkg::SUM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [1:0]              r_kind, n_kind;
    logic [2*RT_W-1:0]       r_rad, n_rad;
    logic [RT_W:0]           r_rem, n_rem;
    logic [RT_W-1:0]         r_root, n_root;
    logic [LVL_W-1:0]        r_top [TOP];
    logic [LVL_W-1:0]        n_top [TOP];
    logic [TCNT_W-1:0]       r_tcnt, n_tcnt;
    logic [LVL_W-1:0]        r_cal_level, n_cal_level;
    logic                    r_calibrated, n_calibrated;
    logic [DN_W-1:0]         r_num, n_num;
    logic [TCNT_W-1:0]       r_drem, n_drem;
    logic [rlbd_pkg::STEP_W-1:0] r_step, n_step;
    rlbd_pkg::t_result       r_res, n_res;
    logic                    r_ov, n_ov;
    rlbd_pkg::t_result       r_out, n_out;

    logic                    act_valid;
    logic [LVL_W-1:0]        act_lvl;
    logic [SUM_W+7:0]        ms_full;
    logic [RT_W+2:0]         sq_tmp, sq_trial, sq_diff;
    logic                    sq_ge;
    logic [RT_W+LVL_W-1:0]   root_ext;
    logic [LVL_W-1:0]        rms;
    logic [DET_W-1:0]        t_rms, t_lo, t_hi;
    logic [DN_W-1:0]         top_sum;
    logic [TCNT_W:0]         dv_tmp, dv_diff;
    logic                    dv_ge;
    logic                    full;
    logic [TCNT_W-1:0]       limit;
    logic [TCNT_W-1:0]       ins_pos;
    logic                    do_ins;
    logic [LVL_W-1:0]        ins_top [TOP];

    assign act_valid = r_calibrated | i_cfg.valid;
    assign act_lvl   = r_calibrated ? r_cal_level : (i_cfg.valid ? i_cfg.level : '0);
    assign ms_full   = {i_q_job.sum, 8'd0};
    assign o_pop     = (r_state == ST_IDLE) & i_q_valid;
    assign o_out_valid = r_ov;
    assign o_res       = r_out;

    // square root, one result bit per cycle
    assign sq_tmp   = {r_rem, r_rad[2*RT_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_tmp >= sq_trial);
    assign sq_diff  = sq_tmp - sq_trial;

    assign root_ext = {{LVL_W{1'b0}}, r_root};
    assign rms = (root_ext > {{RT_W{1'b0}}, {LVL_W{1'b1}}}) ? {LVL_W{1'b1}} : LVL_W'(r_root);

    assign t_rms = DET_W'(rms) * DET_W'(rlbd_pkg::BAND_SCALE);
    assign t_lo  = DET_W'(act_lvl) * DET_W'(rlbd_pkg::BAND_LO);
    assign t_hi  = DET_W'(act_lvl) * DET_W'(rlbd_pkg::BAND_HI);

    // mean of kept values, one quotient bit per cycle
    assign dv_tmp  = {r_drem, r_num[DN_W-1]};
    assign dv_ge   = (dv_tmp >= {1'b0, r_tcnt});
    assign dv_diff = dv_tmp - {1'b0, r_tcnt};

    assign full  = (r_tcnt == TCNT_W'(TOP));
    assign limit = full ? TCNT_W'(TOP - 1) : r_tcnt;
    assign do_ins = ~full | (rms > r_top[TOP-1]);

    always_comb begin
        top_sum = '0;
        for (int i = 0; i < TOP; i++) begin
            top_sum = top_sum + DN_W'(r_top[i]);
        end
    end

    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < TOP; i++) begin
            if ((TCNT_W'(i) < limit) && (r_top[i] >= rms)) begin
                ins_pos = ins_pos + 1'b1;
            end
        end
        for (int i = 0; i < TOP; i++) begin
            if (TCNT_W'(i) < ins_pos) begin
                ins_top[i] = r_top[i];
            end else if (TCNT_W'(i) == ins_pos) begin
                ins_top[i] = rms;
            end else begin
                ins_top[i] = r_top[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_rad        = r_rad;
        n_rem        = r_rem;
        n_root       = r_root;
        n_top        = r_top;
        n_tcnt       = r_tcnt;
        n_cal_level  = r_cal_level;
        n_calibrated = r_calibrated;
        n_num        = r_num;
        n_drem       = r_drem;
        n_step       = r_step;
        n_res        = r_res;
        n_ov         = r_ov;
        n_out        = r_out;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_kind = i_q_job.kind;
                    if (i_q_job.kind == rlbd_pkg::KIND_FINISH) begin
                        if (r_tcnt == '0) begin
                            n_res.kind       = rlbd_pkg::KIND_FINISH;
                            n_res.rms        = '0;
                            n_res.detected   = 1'b0;
                            n_res.new_level  = act_lvl;
                            n_res.no_windows = 1'b1;
                            n_state          = ST_OUT;
                        end else begin
                            n_num   = top_sum;
                            n_drem  = '0;
                            n_step  = rlbd_pkg::STEP_W'(DN_W - 1);
                            n_state = ST_DIV;
                        end
                    end else begin
                        n_rad   = (2*RT_W)'(ms_full[SUM_W+7:rlbd_pkg::WIN_LOG]);
                        n_rem   = '0;
                        n_root  = '0;
                        n_step  = rlbd_pkg::STEP_W'(RT_W - 1);
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                n_rad  = {r_rad[2*RT_W-3:0], 2'b00};
                n_rem  = sq_ge ? sq_diff[RT_W:0] : sq_tmp[RT_W:0];
                n_root = {r_root[RT_W-2:0], sq_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_res.rms        = rms;
                n_res.new_level  = '0;
                n_res.no_windows = 1'b0;
                if (r_kind == rlbd_pkg::KIND_CAL) begin
                    n_res.kind     = rlbd_pkg::KIND_CAL;
                    n_res.detected = 1'b0;
                    if (do_ins) begin
                        n_top = ins_top;
                        if (!full) begin
                            n_tcnt = r_tcnt + 1'b1;
                        end
                    end
                end else begin
                    n_res.kind     = rlbd_pkg::KIND_DETECT;
                    n_res.detected = act_valid & (t_rms >= t_lo) & (t_rms <= t_hi);
                end
                n_state = ST_OUT;
            end
            ST_DIV: begin
                n_drem = dv_ge ? dv_diff[TCNT_W-1:0] : dv_tmp[TCNT_W-1:0];
                n_num  = {r_num[DN_W-2:0], dv_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_cal_level      = n_num[LVL_W-1:0];
                    n_calibrated     = 1'b1;
                    n_res.kind       = rlbd_pkg::KIND_FINISH;
                    n_res.rms        = '0;
                    n_res.detected   = 1'b0;
                    n_res.new_level  = n_num[LVL_W-1:0];
                    n_res.no_windows = 1'b0;
                    n_state          = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                    if (r_kind == rlbd_pkg::KIND_FINISH) begin
                        n_tcnt = '0;
                        for (int i = 0; i < TOP; i++) begin
                            n_top[i] = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tcnt       <= '0;
            r_cal_level  <= '0;
            r_calibrated <= 1'b0;
            r_ov         <= 1'b0;
            for (int i = 0; i < TOP; i++) begin
                r_top[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_tcnt       <= n_tcnt;
            r_cal_level  <= n_cal_level;
            r_calibrated <= n_calibrated;
            r_ov         <= n_ov;
            r_top        <= n_top;
        end
        r_kind <= n_kind;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_num  <= n_num;
        r_drem <= n_drem;
        r_step <= n_step;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_calibrated))
        else $error("calibrated flag cleared");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= TCNT_W'(TOP))
        else $error("kept count out of range");

    a_sqrt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_kind != rlbd_pkg::KIND_FINISH))
        else $error("square root started for a finish job");

endmodule
`default_nettype wire

/* sv/rms_level_band_detector_top.sv */
// windowed rms level detector with calibration
// input channel: i_in_valid / o_in_stall carry i_mode and i_sample; a transfer
// happens on a rising edge with valid high and stall low. mode 0 and 1 feed a
// detection or calibration window of 1024 samples, mode 2 finishes calibration,
// mode 3 is taken and ignored.
// output channel: o_out_valid / i_out_stall carry one result per finished
// window or finish request.
// throughput: one sample per cycle. the front end stalls only when its two
// entry job queue is full, i.e. when two window or finish results are pending.
// with the back end idle, a window result passes through the queue, a
// bit-serial square root and the band compare (or the kept-value update for
// calibration); a finish result passes through a bit-serial divide by the kept
// count, and goes straight to the output when nothing is kept.
// a stalled receiver holds the result register; the back end then waits with
// the next result and the queue fills behind it.
// config: i_cfg_we writes stored_level (index 0) or stored_valid (index 1);
// write only while the block is idle.
// reset (synchronous, active low) clears the window, the kept values, the
// calibration and the configuration registers.
`default_nettype none
module rms_level_band_detector_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [rlbd_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_kind,
    output logic [rlbd_pkg::LVL_W-1:0]         o_rms_level,
    output logic                               o_detected,
    output logic [rlbd_pkg::LVL_W-1:0]         o_new_level,
    output logic                               o_no_windows,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [rlbd_pkg::LVL_W-1:0]    i_cfg_data
);

    rlbd_pkg::t_cfg    r_cfg;
    rlbd_pkg::t_job    push_job, q_job;
    rlbd_pkg::t_result res;
    logic              push, pop, q_full, q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlbd_pkg::CFG_STORED_LEVEL: r_cfg.level <= i_cfg_data;
                rlbd_pkg::CFG_STORED_VALID: r_cfg.valid <= i_cfg_data[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    rlbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_sample   (i_sample),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    rlbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rlbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_kind       = res.kind;
    assign o_rms_level  = res.rms;
    assign o_detected   = res.detected;
    assign o_new_level  = res.new_level;
    assign o_no_windows = res.no_windows;

endmodule
`default_nettype wire
